// File: hdl/rde_pkg.sv
// shared types and constants for the radix digit emitter
// no dependencies; used by radix_digit_emitter_top, rde_ram users and rde_checker

package rde_pkg;

    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 8;
    localparam int BASE_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int IN_W      = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

    localparam logic [BASE_W-1:0] RADIX_RESET      = 5'd10;
    // "01234567" and "89abcdef", digit 0 in the low byte
    localparam logic [CFG_W-1:0]  CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]  CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

// File: hdl/radix_digit_emitter_top.sv
// radix digit emitter: one value in, its digits out as characters, most significant first
// operation: D digits, each found by one shared byte-wide divide step run over the value
// a byte at a time, least significant digit first; the digits are then read back from the
// ram and registered, one character per cycle while m_ready holds; no new value until all are read
// reset: synchronous active-low aresetn; radix 10, alphabet "0123456789abcdef", no clearing pass
// depends on rde_pkg and rde_ram

module radix_digit_emitter_top #(
    parameter int VALUE_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rde_pkg::IN_W-1:0]      s_value,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rde_pkg::CHAR_W-1:0]    m_digit_char,
    output logic                          m_last_digit,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rde_pkg::CFG_W-1:0]     cfg_data
);

    localparam int NSTEP    = (VALUE_BITS + 7) / 8;
    localparam int PAD_BITS = NSTEP * 8;
    localparam int STEP_W   = $clog2(NSTEP + 1);
    localparam int DEPTH    = VALUE_BITS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // configuration registers
    logic [rde_pkg::BASE_W-1:0] radix_reg;
    logic [rde_pkg::CFG_W-1:0]  chars_low_reg;
    logic [rde_pkg::CFG_W-1:0]  chars_high_reg;
    logic [rde_pkg::BASE_W-1:0] base;

    rde_pkg::state_t             state_reg, state_next;
    logic [PAD_BITS-1:0]         val_reg, val_next;
    logic [rde_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CNT_W-1:0]            cnt_dec;

    logic                        rd_valid_reg, rd_valid_next;
    logic                        rd_last_reg, rd_last_next;
    logic                        m_valid_reg, m_valid_next;
    logic [rde_pkg::CHAR_W-1:0]  m_char_reg, m_char_next;
    logic                        m_last_reg, m_last_next;

    // divide step signals
    logic [7:0]                  div_byte;
    logic [7:0]                  quo_byte;
    logic [rde_pkg::DIGIT_W-1:0] part_rem;
    logic [rde_pkg::BASE_W-1:0]  trial;
    logic [PAD_BITS-1:0]         val_shift;
    logic                        last_step;

    logic                        ram_we;
    logic                        ram_re;
    logic [rde_pkg::DIGIT_W-1:0] ram_rdata;
    logic                        out_free;
    logic                        consume;
    logic [rde_pkg::CFG_W-1:0]   char_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= rde_pkg::RADIX_RESET;
            chars_low_reg  <= rde_pkg::CHARS_LOW_RESET;
            chars_high_reg <= rde_pkg::CHARS_HIGH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rde_pkg::CFG_RADIX:      radix_reg      <= cfg_data[rde_pkg::BASE_W-1:0];
                rde_pkg::CFG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                rde_pkg::CFG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // base saturates into 2..16
    always_comb begin
        if (radix_reg < rde_pkg::BASE_MIN) begin
            base = rde_pkg::BASE_MIN;
        end else if (radix_reg > rde_pkg::BASE_MAX) begin
            base = rde_pkg::BASE_MAX;
        end else begin
            base = radix_reg;
        end
    end

    // one byte of long division by the base, top byte of val_reg first
    assign div_byte = val_reg[PAD_BITS-1 -: 8];

    always_comb begin
        part_rem = rem_reg;
        quo_byte = '0;
        trial    = '0;
        for (int i = 7; i >= 0; i--) begin
            trial = {part_rem, div_byte[i]};
            if (trial >= base) begin
                trial       = trial - base;
                quo_byte[i] = 1'b1;
            end
            part_rem = trial[rde_pkg::DIGIT_W-1:0];
        end
    end

    assign rem_next  = part_rem;
    assign val_shift = (val_reg << 8) | PAD_BITS'(quo_byte);
    assign last_step = (step_reg == STEP_W'(NSTEP - 1));
    assign cnt_dec   = cnt_reg - CNT_W'(1);

    assign out_free = !m_valid_reg || m_ready;
    assign consume  = rd_valid_reg && out_free;

    always_comb begin
        state_next    = state_reg;
        val_next      = val_reg;
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        rd_last_next  = rd_last_reg;
        rd_valid_next = consume ? 1'b0 : rd_valid_reg;
        unique case (state_reg)
            rde_pkg::ST_IDLE: begin
                if (s_valid) begin
                    val_next   = PAD_BITS'(s_value[VALUE_BITS-1:0]);
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = rde_pkg::ST_DIV;
                end
            end
            rde_pkg::ST_DIV: begin
                val_next = val_shift;
                if (last_step) begin
                    // remainder of the full pass is the next digit, least significant first
                    ram_we    = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    step_next = '0;
                    if (val_shift == '0) begin
                        state_next = rde_pkg::ST_EMIT;
                    end
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            rde_pkg::ST_EMIT: begin
                // read digits back from the top of the stack
                if (cnt_reg != '0 && (!rd_valid_reg || consume)) begin
                    ram_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_last_next  = (cnt_reg == CNT_W'(1));
                    cnt_next      = cnt_dec;
                end else if (cnt_reg == '0 && !rd_valid_reg) begin
                    state_next = rde_pkg::ST_IDLE;
                end
            end
            default: state_next = rde_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rde_pkg::ST_IDLE;
            rem_reg      <= '0;
            step_reg     <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            // remainder restarts at zero for each new digit
            rem_reg      <= (state_reg == rde_pkg::ST_DIV && !last_step) ? rem_next : '0;
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        rd_last_reg <= rd_last_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    rde_ram #(
        .WIDTH (rde_pkg::DIGIT_W),
        .DEPTH (DEPTH)
    ) u_digit_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (rem_next),
        .re    (ram_re),
        .raddr (cnt_dec[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // alphabet lookup on the way into the output register
    assign char_word = ram_rdata[3] ? chars_high_reg : chars_low_reg;

    always_comb begin
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        if (consume) begin
            m_char_next  = char_word[{ram_rdata[2:0], 3'b000} +: rde_pkg::CHAR_W];
            m_last_next  = rd_last_reg;
            m_valid_next = 1'b1;
        end
    end

    assign s_ready      = (state_reg == rde_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_char_reg;
    assign m_last_digit = m_last_reg;

endmodule

// File: hdl/rde_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module rde_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/rde_checker.sv
// port-level checks for radix_digit_emitter_top, attached by bind
// depends on rde_pkg for field widths

module rde_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rde_pkg::CHAR_W-1:0]    m_digit_char,
    input logic                          m_last_digit,
    input logic                          cfg_ready
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_char) && $stable(m_last_digit))
        else $error("result changed while stalled");

    // after a value is taken the block is busy with it
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transaction");

    // characters only appear while a value is being worked on
    a_emit_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !s_ready)
        else $error("result appeared while idle");

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready && cfg_ready)
        else $error("block not idle after reset");

endmodule

bind radix_digit_emitter_top rde_checker u_rde_checker (.*);

// File: tb/tb.sv
// self-checking testbench for radix_digit_emitter_top: a directed table, then random phases
// every digit character is predicted in the bench and scoreboarded on the result channel
// depends on rde_pkg and the radix_digit_emitter_top rtl

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rde_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int DRAIN_CYCLES    = 600;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 26;
    localparam int MAX_DIGITS      = 64;
    localparam logic [IN_W-1:0] ALL_ONES = '1;

    typedef enum logic {
        ROW_CFG,
        ROW_NUM
    } row_kind_t;

    // want holds the typed-in digit string, empty means use the predictor
    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
        string                  want;
    } stim_row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [IN_W-1:0]       s_value   = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [CHAR_W-1:0]     m_digit_char;
    logic                  m_last_digit;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RADIX;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // shadow copy of the register file
    logic [BASE_W-1:0]     radix_q    = RADIX_RESET;
    logic [CFG_W-1:0]      chars_lo_q = CHARS_LOW_RESET;
    logic [CFG_W-1:0]      chars_hi_q = CHARS_HIGH_RESET;

    digit_t      expected_digits[$];
    digit_t      head_digit;
    int unsigned n_numbers = 0;
    int unsigned n_digits  = 0;
    int unsigned n_writes  = 0;
    int unsigned n_errors  = 0;
    int unsigned cycles    = 0;
    int unsigned stall_left = 0;
    int unsigned run_left   = 0;
    bit          steady    = 1'b0;

    stim_row_t directed_rows[$] = '{
        '{ROW_NUM, CFG_RADIX,      64'd0,                  "0"},
        '{ROW_NUM, CFG_RADIX,      ALL_ONES,               "18446744073709551615"},
        '{ROW_NUM, CFG_RADIX,      64'd9,                  "9"},
        '{ROW_NUM, CFG_RADIX,      64'd10,                 "10"},
        '{ROW_CFG, CFG_RADIX,      64'(BASE_MIN),          ""},
        '{ROW_NUM, CFG_RADIX,      ALL_ONES,               ""},
        '{ROW_NUM, CFG_RADIX,      64'd0,                  "0"},
        '{ROW_NUM, CFG_RADIX,      64'h8000_0000_0000_0000, ""},
        '{ROW_CFG, CFG_RADIX,      64'(BASE_MAX),          ""},
        '{ROW_NUM, CFG_RADIX,      ALL_ONES,               "ffffffffffffffff"},
        '{ROW_NUM, CFG_RADIX,      64'h0123_4567_89AB_CDEF, "123456789abcdef"},
        '{ROW_NUM, CFG_RADIX,      64'hFEDC_BA98_7654_3210, "fedcba9876543210"},
        // base codes below two and above sixteen saturate
        '{ROW_CFG, CFG_RADIX,      64'd0,                  ""},
        '{ROW_NUM, CFG_RADIX,      64'd5,                  "101"},
        '{ROW_CFG, CFG_RADIX,      64'd1,                  ""},
        '{ROW_NUM, CFG_RADIX,      64'd6,                  "110"},
        '{ROW_CFG, CFG_RADIX,      64'd31,                 ""},
        '{ROW_NUM, CFG_RADIX,      64'd255,                "ff"},
        '{ROW_CFG, CFG_RADIX,      64'd17,                 ""},
        '{ROW_NUM, CFG_RADIX,      64'd16,                 "10"},
        // upper data bits dropped, radix lands on 8
        '{ROW_CFG, CFG_RADIX,      64'hFFFF_FFFF_FFFF_FFE8, ""},
        '{ROW_NUM, CFG_RADIX,      64'd64,                 "100"},
        // write to a missing register must not touch anything
        '{ROW_CFG, CFG_UNUSED,     64'd3,                  ""},
        '{ROW_NUM, CFG_RADIX,      64'd8,                  "10"},
        '{ROW_CFG, CFG_RADIX,      64'(BASE_MAX),          ""},
        '{ROW_CFG, CFG_CHARS_LOW,  64'h4847_4645_4443_4241, ""},
        '{ROW_CFG, CFG_CHARS_HIGH, 64'h504F_4E4D_4C4B_4A49, ""},
        '{ROW_NUM, CFG_RADIX,      64'h0123_4567_89AB_CDEF, "BCDEFGHIJKLMNOP"},
        '{ROW_NUM, CFG_RADIX,      64'd0,                  "A"},
        '{ROW_CFG, CFG_CHARS_LOW,  64'd0,                  ""},
        '{ROW_CFG, CFG_CHARS_HIGH, ALL_ONES,               ""},
        '{ROW_NUM, CFG_RADIX,      64'h80F,                ""},
        '{ROW_NUM, CFG_RADIX,      ALL_ONES,               ""},
        '{ROW_CFG, CFG_CHARS_LOW,  ALL_ONES,               ""},
        '{ROW_CFG, CFG_CHARS_HIGH, 64'd0,                  ""},
        '{ROW_NUM, CFG_RADIX,      64'h0F0F,               ""},
        '{ROW_CFG, CFG_RADIX,      64'(RADIX_RESET),       ""},
        '{ROW_CFG, CFG_CHARS_LOW,  CHARS_LOW_RESET,        ""},
        '{ROW_CFG, CFG_CHARS_HIGH, CHARS_HIGH_RESET,       ""}
    };

    radix_digit_emitter_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // digits of v in the current base, most significant first, queued as characters
    function automatic void predict_digits(logic [IN_W-1:0] v);
        logic [IN_W-1:0]    base;
        logic [IN_W-1:0]    rest;
        logic [DIGIT_W-1:0] digs [MAX_DIGITS];
        logic [CFG_W-1:0]   word;
        int                 n;
        int                 k;
        if (radix_q < BASE_MIN)
            base = IN_W'(BASE_MIN);
        else if (radix_q > BASE_MAX)
            base = IN_W'(BASE_MAX);
        else
            base = IN_W'(radix_q);
        rest = v;
        n = 0;
        do begin
            digs[n] = DIGIT_W'(rest % base);
            rest = rest / base;
            n++;
        end while (rest != 0 && n < MAX_DIGITS);
        for (k = n - 1; k >= 0; k--) begin
            word = digs[k][DIGIT_W-1] ? chars_hi_q : chars_lo_q;
            expected_digits.push_back('{word[digs[k][2:0]*CHAR_W +: CHAR_W], k == 0});
        end
    endfunction

    function automatic void expect_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            expected_digits.push_back('{s[i], i == s.len() - 1});
    endfunction

    function automatic void flag_error(string what, digit_t want_d);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch %0d: %s, expected char 0x%02h last %0b, got char 0x%02h last %0b",
                     n_errors, what, want_d.ch, want_d.last, m_digit_char, m_last_digit);
    endfunction

    function automatic logic [IN_W-1:0] random_value();
        logic [IN_W-1:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            2: return IN_W'($urandom_range(0, 300));
            default: return raw >> $urandom_range(0, 63);
        endcase
    endfunction

    task automatic wait_idle();
        while (expected_digits.size() != 0)
            @(posedge aclk);
    endtask

    // registers only change with nothing in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        s_valid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_RADIX:      radix_q    = data[BASE_W-1:0];
            CFG_CHARS_LOW:  chars_lo_q = data;
            CFG_CHARS_HIGH: chars_hi_q = data;
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic sender_gap();
        if (!steady && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        // now and then hold off until every digit has drained
        if (!steady && $urandom_range(0, 99) < 3 && expected_digits.size() != 0) begin
            s_valid <= 1'b0;
            wait_idle();
        end
    endtask

    task automatic send_number(logic [IN_W-1:0] v, string want);
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        if (want.len() != 0)
            expect_text(want);
        else
            predict_digits(v);
        n_numbers++;
    endtask

    // result side backpressure in bursts, with stretches of steady ready
    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (run_left > 0) begin
            m_ready <= 1'b1;
            run_left--;
        end else if ($urandom_range(0, 99) < 40) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(1, 10) - 1;
        end else begin
            m_ready <= 1'b1;
            run_left = $urandom_range(1, 20) - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_digits.size() == 0) begin
                flag_error("transaction with nothing expected", '{'0, 1'b0});
            end else begin
                head_digit = expected_digits.pop_front();
                if (head_digit.ch !== m_digit_char || head_digit.last !== m_last_digit)
                    flag_error("digit differs", head_digit);
                n_digits++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digits outstanding",
                     cycles, expected_digits.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int                p;
        int                i;
        logic [BASE_W-1:0] r5;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                cfg_valid <= 1'b0;
                sender_gap();
                send_number(directed_rows[r].data, directed_rows[r].want);
            end
        end

        for (p = 0; p < RANDOM_PHASES; p++) begin
            // last phase runs with no idling on either side
            if (p == RANDOM_PHASES - 1)
                steady = 1'b1;
            if (p == 0)
                r5 = BASE_MIN;
            else if (p == 1)
                r5 = BASE_MAX;
            else if ($urandom_range(0, 3) == 0)
                r5 = BASE_W'($urandom_range(0, 31));
            else
                r5 = BASE_W'($urandom_range(2, 16));
            write_reg(CFG_RADIX, {$urandom, 27'($urandom), r5});
            if (p % 2 == 0) begin
                write_reg(CFG_CHARS_LOW, {$urandom, $urandom});
                write_reg(CFG_CHARS_HIGH, {$urandom, $urandom});
            end else begin
                write_reg(CFG_CHARS_LOW, CHARS_LOW_RESET);
                write_reg(CFG_CHARS_HIGH, CHARS_HIGH_RESET);
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                cfg_valid <= 1'b0;
                sender_gap();
                send_number(random_value(), "");
            end
        end

        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("converted %0d numbers across %0d register writes, bases 2..16 plus saturating codes",
                 n_numbers, n_writes);
        $display("compared %0d digit characters, %0d mismatches", n_digits, n_errors);
        if (n_errors == 0 && expected_digits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hdl/rde_pkg.sv
hdl/rde_ram.sv
hdl/radix_digit_emitter_top.sv
hdl/rde_checker.sv
tb/tb.sv
